// ----- sv/lcd_window_pixel_framer_assert.svh -----
// Assertion macros shared by the framer checks.
`ifndef LCD_WINDOW_PIXEL_FRAMER_ASSERT_SVH
`define LCD_WINDOW_PIXEL_FRAMER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define LWPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define LWPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define LWPF_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lwpf_pkg.sv -----
// Shared widths, register indexes, command codes and byte positions of the framer.
package lwpf_pkg;

  localparam int COORD_W    = 16;
  localparam int IN_DATA_W  = 5 * COORD_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = COORD_W;
  localparam int POS_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 4'd1;

  localparam logic [COORD_W-1:0] COLUMN_OFFSET_RST = 16'd40;
  localparam logic [COORD_W-1:0] ROW_OFFSET_RST    = 16'd53;

  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [OUT_DATA_W-1:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [OUT_DATA_W-1:0] CMD_ROW_SET    = 8'h2B;
  localparam logic [OUT_DATA_W-1:0] CMD_MEM_WRITE  = 8'h2C;

  // Byte positions within a window request.
  localparam logic [POS_W-1:0] POS_COL_CMD = 4'd0;
  localparam logic [POS_W-1:0] POS_XS_HI   = 4'd1;
  localparam logic [POS_W-1:0] POS_XS_LO   = 4'd2;
  localparam logic [POS_W-1:0] POS_XE_HI   = 4'd3;
  localparam logic [POS_W-1:0] POS_XE_LO   = 4'd4;
  localparam logic [POS_W-1:0] POS_ROW_CMD = 4'd5;
  localparam logic [POS_W-1:0] POS_YS_HI   = 4'd6;
  localparam logic [POS_W-1:0] POS_YS_LO   = 4'd7;
  localparam logic [POS_W-1:0] POS_YE_HI   = 4'd8;
  localparam logic [POS_W-1:0] POS_YE_LO   = 4'd9;
  localparam logic [POS_W-1:0] POS_MEM_CMD = 4'd10;

  // Byte positions within a pixel request.
  localparam logic [POS_W-1:0] POS_PIX_HI = 4'd0;

endpackage

// ----- sv/lcd_window_pixel_framer.sv -----
// Framer that turns window and pixel requests into SPI LCD command and data bytes.
//
// One request enters per accepted input beat and leaves as a run of bytes, one byte
// per clock on the output channel unless out_tready stalls it: a window request is
// 11 bytes and a pixel request 2. The rate is set by the single output byte
// register, which the byte sequencer loads once per cycle unless stalled. A
// request is captured into the request registers and its first byte then moves to
// the output register. The next request is taken in the cycle that the last byte of
// the current one moves to the output register, so requests follow with no gap;
// while the output register waits on out_tready the sequencer holds and the input
// stalls. Offsets are added to window coordinates when a request is captured.
module lcd_window_pixel_framer (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg_index: register index; cfg_data: register value
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lwpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lwpf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: x_start, y_start, x_end, y_end, pixel (16 bits each, lowest first)
  input  logic [lwpf_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: operation
  input  logic [lwpf_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: out_byte
  output logic [lwpf_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: data_flag, release_select
  output logic [lwpf_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast
);

  import lwpf_pkg::*;

  logic [COORD_W-1:0] col_off_r;
  logic [COORD_W-1:0] row_off_r;

  logic               item_valid_r;
  logic               op_r;
  logic [POS_W-1:0]   pos_r;
  logic [COORD_W-1:0] w0_r, w1_r, w2_r, w3_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_byte_r;
  logic                  out_data_r;
  logic                  out_rel_r;
  logic                  out_last_r;

  logic [COORD_W-1:0] in_xs, in_ys, in_xe, in_ye, in_pix;
  logic               in_accept;
  logic               advance;

  logic [OUT_DATA_W-1:0] sel_byte;
  logic                  sel_data;
  logic                  sel_rel;
  logic                  sel_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r <= COLUMN_OFFSET_RST;
      row_off_r <= ROW_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLUMN_OFFSET: col_off_r <= cfg_data;
        CFG_ROW_OFFSET:    row_off_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_xs  = in_tdata[0*COORD_W +: COORD_W];
  assign in_ys  = in_tdata[1*COORD_W +: COORD_W];
  assign in_xe  = in_tdata[2*COORD_W +: COORD_W];
  assign in_ye  = in_tdata[3*COORD_W +: COORD_W];
  assign in_pix = in_tdata[4*COORD_W +: COORD_W];

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || (advance && sel_last);
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    sel_byte = CMD_MEM_WRITE;
    sel_data = 1'b1;
    sel_rel  = 1'b1;
    sel_last = 1'b0;
    if (op_r == OP_PIXEL) begin
      if (pos_r == POS_PIX_HI) begin
        sel_byte = w0_r[15:8];
        sel_rel  = 1'b0;
      end else begin
        sel_byte = w0_r[7:0];
        sel_last = 1'b1;
      end
    end else begin
      case (pos_r)
        POS_COL_CMD: begin
          sel_byte = CMD_COLUMN_SET;
          sel_data = 1'b0;
        end
        POS_XS_HI: begin
          sel_byte = w0_r[15:8];
          sel_rel  = 1'b0;
        end
        POS_XS_LO: sel_byte = w0_r[7:0];
        POS_XE_HI: begin
          sel_byte = w1_r[15:8];
          sel_rel  = 1'b0;
        end
        POS_XE_LO: sel_byte = w1_r[7:0];
        POS_ROW_CMD: begin
          sel_byte = CMD_ROW_SET;
          sel_data = 1'b0;
        end
        POS_YS_HI: begin
          sel_byte = w2_r[15:8];
          sel_rel  = 1'b0;
        end
        POS_YS_LO: sel_byte = w2_r[7:0];
        POS_YE_HI: begin
          sel_byte = w3_r[15:8];
          sel_rel  = 1'b0;
        end
        POS_YE_LO: sel_byte = w3_r[7:0];
        default: begin
          sel_byte = CMD_MEM_WRITE;
          sel_data = 1'b0;
          sel_last = 1'b1;
        end
      endcase
    end
  end

  // Hold the request and step through its bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      pos_r        <= '0;
    end else if (in_accept) begin
      item_valid_r <= 1'b1;
      pos_r        <= '0;
    end else if (advance) begin
      if (sel_last) begin
        item_valid_r <= 1'b0;
        pos_r        <= '0;
      end else begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= in_tuser[0];
      if (in_tuser[0] == OP_PIXEL) begin
        w0_r <= in_pix;
      end else begin
        w0_r <= in_xs + col_off_r;
        w1_r <= in_xe + col_off_r;
        w2_r <= in_ys + row_off_r;
        w3_r <= in_ye + row_off_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= sel_byte;
      out_data_r <= sel_data;
      out_rel_r  <= sel_rel;
      out_last_r <= sel_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_rel_r, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/lwpf_checker.sv -----
// Port-level checks of the framer, bound to its top level.
`include "lcd_window_pixel_framer_assert.svh"

module lwpf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lwpf_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [lwpf_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  import lwpf_pkg::*;

  `LWPF_ASSERT_NXT_ALL(a_reset_clears_out, clk, !rst_n, !out_tvalid, "out_tvalid after reset")

  `LWPF_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output byte changed")

  `LWPF_ASSERT_IMP(a_cmd_releases, clk, rst_n, out_tvalid && !out_tuser[0], out_tuser[1], "command byte keeps select")

  `LWPF_ASSERT_IMP(a_last_releases, clk, rst_n, out_tvalid && out_tlast, out_tuser[1], "final byte keeps select")

endmodule

bind lcd_window_pixel_framer lwpf_checker u_lwpf_checker (.*);
